// ===== rtl/smt_pkg.sv =====
// package: shared constants and types of the sorted greedy threshold matcher
package smt_pkg;

    localparam int MAX_PAIRS_DEF  = 256;
    localparam int VALUE_BITS_DEF = 16;
    localparam int COUNT_BITS     = 9;
    localparam int QUEUE_DEPTH    = 2;

    typedef struct packed {
        logic store;
        logic drop;
        logic last;
    } t_item_ctrl;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_WALK,
        ST_DONE
    } t_back_state;

endpackage

// ===== rtl/smt_if.sv =====
// interfaces: input pair channel and result channel
interface smt_in_if #(parameter int VALUE_BITS = 16);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] demand_value;
    logic [VALUE_BITS-1:0] capacity_value;
    logic                  last_pair;

    modport source (output valid, demand_value, capacity_value, last_pair, input ready);
    modport sink (input valid, demand_value, capacity_value, last_pair, output ready);
endinterface

interface smt_out_if;
    logic       valid;
    logic       ready;
    logic [8:0] matched_count;
    logic       overflow_flag;

    modport source (output valid, matched_count, overflow_flag, input ready);
    modport sink (input valid, matched_count, overflow_flag, output ready);
endinterface

// ===== rtl/sorted_greedy_threshold_matcher.sv =====
// top level: sorted greedy threshold matcher
//
// i_in carries one demand/capacity pair per item, last_pair closes a case.
// o_out carries one result per case: matched_count and overflow_flag.
// pairs are taken one per cycle unless the queue is full, and inserted
// into two sorted cell rows. pairs beyond MAX_PAIRS in a case are dropped
// and set overflow_flag. once the closing item reaches the back end, the
// matching walk drains the rows, one capacity entry per step, until
// either row is empty; then the result register is loaded.
// during the walk the two-entry queue fills and i_in.ready falls; the
// front end takes items again as the next case starts loading.
// a result waits in its register while the next case loads; only the
// end of the next walk stalls until o_out.ready takes it.
// after reset (i_rst_n low at a clock edge) the rows and queue are empty.
module sorted_greedy_threshold_matcher
    import smt_pkg::*;
#(
    parameter int MAX_PAIRS  = MAX_PAIRS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smt_in_if.sink     i_in,
    smt_out_if.source  o_out
);
    localparam int Q_W = 2 * VALUE_BITS + $bits(t_item_ctrl);

    logic                  push;
    logic                  full;
    logic                  q_valid;
    logic                  pop;
    logic [VALUE_BITS-1:0] f_dem;
    logic [VALUE_BITS-1:0] f_cap;
    t_item_ctrl            f_ctrl;
    logic [Q_W-1:0]        q_out;
    t_item_ctrl            b_ctrl;

    smt_front #(.MAX_PAIRS(MAX_PAIRS), .VALUE_BITS(VALUE_BITS)) u_front (
        .i_clk, .i_rst_n, .i_in, .o_push(push), .o_demand(f_dem),
        .o_capacity(f_cap), .o_ctrl(f_ctrl), .i_full(full)
    );

    smt_fifo #(.WIDTH(Q_W)) u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_data({f_dem, f_cap, f_ctrl}),
        .o_full(full), .i_pop(pop), .o_valid(q_valid), .o_data(q_out)
    );

    assign b_ctrl = q_out[$bits(t_item_ctrl)-1:0];

    smt_back #(.MAX_PAIRS(MAX_PAIRS), .VALUE_BITS(VALUE_BITS)) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid),
        .i_demand(q_out[Q_W-1 -: VALUE_BITS]),
        .i_capacity(q_out[$bits(t_item_ctrl) +: VALUE_BITS]),
        .i_ctrl(b_ctrl), .o_pop(pop), .o_out
    );
endmodule

// ===== rtl/smt_front.sv =====
// front end: accepts pairs and marks each as stored or dropped
module smt_front
    import smt_pkg::*;
#(
    parameter int MAX_PAIRS  = MAX_PAIRS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    smt_in_if.sink                i_in,
    output logic                  o_push,
    output logic [VALUE_BITS-1:0] o_demand,
    output logic [VALUE_BITS-1:0] o_capacity,
    output t_item_ctrl            o_ctrl,
    input  logic                  i_full
);
    localparam int CNT_W = $clog2(MAX_PAIRS + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             store;

    assign i_in.ready  = !i_full;
    assign o_push      = i_in.valid && !i_full;
    assign o_demand    = i_in.demand_value;
    assign o_capacity  = i_in.capacity_value;
    assign store       = r_cnt < CNT_W'(MAX_PAIRS);
    assign o_ctrl      = '{store: store, drop: !store, last: i_in.last_pair};

    always_comb begin
        n_cnt = r_cnt;
        if (o_push) begin
            if (i_in.last_pair) begin
                n_cnt = '0;
            end else if (store) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end
endmodule

// ===== rtl/smt_fifo.sv =====
// short queue between front end and back end
module smt_fifo
    import smt_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_cnt;

    assign o_full  = r_cnt == (PTR_W+1)'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            r_cnt <= r_cnt + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end
endmodule

// ===== rtl/smt_sort_row.sv =====
// row of insertion sorter cells, drained from the head
module smt_sort_row
    import smt_pkg::*;
#(
    parameter int MAX_PAIRS  = MAX_PAIRS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ins,
    input  logic [VALUE_BITS-1:0] i_key,
    input  logic                  i_shift,
    input  logic                  i_clear,
    output logic [VALUE_BITS-1:0] o_head,
    output logic                  o_head_valid
);
    logic [VALUE_BITS-1:0] r_val [MAX_PAIRS];
    logic [MAX_PAIRS-1:0]  r_v;
    logic [MAX_PAIRS-1:0]  lt;

    assign o_head       = r_val[0];
    assign o_head_valid = r_v[0];

    for (genvar i = 0; i < MAX_PAIRS; i++) begin : g_cell
        logic                  prev_v;
        logic                  prev_lt;
        logic [VALUE_BITS-1:0] prev_val;
        logic                  next_v;
        logic [VALUE_BITS-1:0] next_val;

        assign lt[i] = !r_v[i] || (i_key < r_val[i]);

        if (i == 0) begin : g_first
            assign prev_v   = 1'b1;
            assign prev_lt  = 1'b0;
            assign prev_val = i_key;
        end else begin : g_rest
            assign prev_v   = r_v[i-1];
            assign prev_lt  = lt[i-1];
            assign prev_val = r_val[i-1];
        end

        if (i == MAX_PAIRS - 1) begin : g_end
            assign next_v   = 1'b0;
            assign next_val = r_val[i];
        end else begin : g_mid
            assign next_v   = r_v[i+1];
            assign next_val = r_val[i+1];
        end

        always_ff @(posedge i_clk) begin
            if (i_ins) begin
                if (lt[i]) begin
                    r_val[i] <= prev_lt ? prev_val : i_key;
                end
            end else if (i_shift) begin
                r_val[i] <= next_val;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || i_clear) begin
                r_v[i] <= 1'b0;
            end else if (i_ins) begin
                r_v[i] <= r_v[i] || prev_v;
            end else if (i_shift) begin
                r_v[i] <= next_v;
            end
        end
    end
endmodule

// ===== rtl/smt_back.sv =====
// back end: sorts the stored pairs and runs the greedy matching walk
module smt_back
    import smt_pkg::*;
#(
    parameter int MAX_PAIRS  = MAX_PAIRS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  logic [VALUE_BITS-1:0] i_demand,
    input  logic [VALUE_BITS-1:0] i_capacity,
    input  t_item_ctrl            i_ctrl,
    output logic                  o_pop,
    smt_out_if.source             o_out
);
    localparam int CNT_W = $clog2(MAX_PAIRS + 1);

    t_back_state           r_state;
    t_back_state           n_state;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_drop;
    logic                  r_ov;
    logic [COUNT_BITS-1:0] r_count_out;
    logic                  r_flag_out;

    logic                  ins;
    logic                  d_shift;
    logic                  c_shift;
    logic                  clear;
    logic                  both;
    logic                  take;
    logic                  free;
    logic [VALUE_BITS-1:0] d_head;
    logic [VALUE_BITS-1:0] c_head;
    logic                  d_hv;
    logic                  c_hv;

    assign both = d_hv && c_hv;
    assign take = !(c_head < d_head);
    assign free = !r_ov || o_out.ready;

    assign o_out.valid         = r_ov;
    assign o_out.matched_count = r_count_out;
    assign o_out.overflow_flag = r_flag_out;

    smt_sort_row #(.MAX_PAIRS(MAX_PAIRS), .VALUE_BITS(VALUE_BITS)) u_dem (
        .i_clk, .i_rst_n, .i_ins(ins), .i_key(i_demand), .i_shift(d_shift),
        .i_clear(clear), .o_head(d_head), .o_head_valid(d_hv)
    );

    smt_sort_row #(.MAX_PAIRS(MAX_PAIRS), .VALUE_BITS(VALUE_BITS)) u_cap (
        .i_clk, .i_rst_n, .i_ins(ins), .i_key(i_capacity), .i_shift(c_shift),
        .i_clear(clear), .o_head(c_head), .o_head_valid(c_hv)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: if (i_q_valid && i_ctrl.last) n_state = ST_WALK;
            ST_WALK: if (!both) n_state = ST_DONE;
            ST_DONE: if (free) n_state = ST_LOAD;
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        ins     = 1'b0;
        d_shift = 1'b0;
        c_shift = 1'b0;
        clear   = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_pop = i_q_valid;
                ins   = i_q_valid && i_ctrl.store;
            end
            ST_WALK: begin
                c_shift = both;
                d_shift = both && take;
            end
            ST_DONE: clear = free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_drop <= r_drop || i_ctrl.drop;
            end
            if (d_shift) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (clear) begin
                r_cnt  <= '0;
                r_drop <= 1'b0;
                r_ov   <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (clear) begin
            r_count_out <= COUNT_BITS'(r_cnt);
            r_flag_out  <= r_drop;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_PAIRS))
        else $error("match count beyond store depth");
    a_pop_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == ST_LOAD)
        else $error("queue popped outside load phase");
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && free) |=> (r_ov && r_state == ST_LOAD))
        else $error("result not presented after walk");
    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && !both) |=> r_state == ST_DONE)
        else $error("walk did not finish");
endmodule
